// ----- src/tsdf_pkg.sv -----
package tsdf_pkg;

    // point format, cancels out of the arithmetic
    localparam int FRAC_BITS  = 16;
    localparam int SCALE_FRAC = 16;
    localparam int ROT_FRAC   = 18;
    localparam int NORM_FRAC  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    // stream widths
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 88;

    // register stages from input to output register
    localparam int PIPE_DEPTH = 65;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_ROW0     = 3'd0,
        REG_ROT_ROW1     = 3'd1,
        REG_ROT_ROW2     = 3'd2,
        REG_OFFSET_X     = 3'd3,
        REG_OFFSET_Y     = 3'd4,
        REG_OFFSET_Z     = 3'd5,
        REG_SCALE_PAIR   = 3'd6,
        REG_SHAPE_RADIUS = 3'd7
    } reg_idx_t;

    localparam logic [59:0] ROT_ROW0_RST     = 60'h0000_0000_0004_0000;
    localparam logic [59:0] ROT_ROW1_RST     = 60'h0000_0040_0000_0000;
    localparam logic [59:0] ROT_ROW2_RST     = 60'h400_0000_0000_0000;
    localparam logic [47:0] SCALE_PAIR_RST   = 48'h0100_0001_0000;
    localparam logic [31:0] SHAPE_RADIUS_RST = 32'h0001_0000;

    // one step of the bit-pair square root
    typedef struct packed {
        logic [63:0] n;
        logic [63:0] r;
    } root_st_t;

    // one step of the restoring divider
    typedef struct packed {
        logic [33:0] rem;
        logic [16:0] dlo;
        logic [16:0] q;
    } div_st_t;

    // side data carried through the root stages
    typedef struct packed {
        logic signed [31:0] loc_y;
        logic [2:0]         neg;
        logic [2:0][29:0]   sh;
    } root_cy_t;

    // side data carried through the divider stages
    typedef struct packed {
        logic signed [31:0] distance;
        logic               outside;
        logic [32:0]        len;
        logic [2:0]         neg;
    } div_cy_t;

    function automatic logic signed [19:0] rot_el(logic [59:0] row, int unsigned col);
        return row[20*col +: 20];
    endfunction

    function automatic root_st_t root_step(root_st_t a, logic [63:0] bit_v);
        root_st_t    y;
        logic [64:0] t;
        t = {1'b0, a.r} + {1'b0, bit_v};
        if ({1'b0, a.n} >= t) begin
            y.n = a.n - t[63:0];
            y.r = (a.r >> 1) + bit_v;
        end else begin
            y.n = a.n;
            y.r = a.r >> 1;
        end
        return y;
    endfunction

    function automatic div_st_t div_step(div_st_t a, logic [32:0] len);
        div_st_t     y;
        logic [33:0] rem2;
        rem2 = {a.rem[32:0], a.dlo[16]};
        y.dlo = {a.dlo[15:0], 1'b0};
        if (rem2 >= {1'b0, len}) begin
            y.rem = rem2 - {1'b0, len};
            y.q   = {a.q[15:0], 1'b1};
        end else begin
            y.rem = rem2;
            y.q   = {a.q[15:0], 1'b0};
        end
        return y;
    endfunction

endpackage

// ----- src/transformed_sdf_eval.sv -----
// Signed distance and surface normal of one affine-placed sphere or plane for
// each query point. The point is taken into the object frame as
// R^T*(p*inv_scale) - offset; sphere mode returns scale*(|local| - radius) and
// the normalized R*local, plane mode returns local.y and R's second column.
// The block is a 65-stage pipeline and takes one point every cycle while the
// output is not stalled; the length follows from the two 32-step square roots
// and the 17-step dividers for the normal, each one step per stage. A stall
// at the output holds the whole pipeline. Configuration must be written while
// no point is in flight.
module transformed_sdf_eval (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [tsdf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsdf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x, pos_y, pos_z
    input  logic [tsdf_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // distance, normal_x, normal_y, normal_z, outside, one zero pad bit
    output logic [tsdf_pkg::M_DATA_W-1:0]    m_tdata
);
    import tsdf_pkg::*;

    // configuration registers
    logic [59:0]        rot_row_reg [3];
    logic signed [31:0] offset_reg [3];
    logic [47:0]        scale_pair_reg;
    logic [31:0]        shape_radius_reg;

    logic [23:0] scale;
    logic [23:0] inv_scale;
    logic [30:0] radius;
    logic        plane;

    // pipeline control
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  adv;

    // stage registers
    logic signed [56:0]  p1_reg [3];
    logic signed [40:0]  q2_reg [3];
    logic signed [60:0]  m3_reg [3][3];
    logic signed [62:0]  acc4_reg [3];
    logic signed [31:0]  loc5_reg [3];
    logic [62:0]         sqp6_reg [3];
    logic signed [51:0]  vp6_reg [3][3];
    logic signed [31:0]  locy6_reg;
    logic [63:0]         sqd7_reg;
    logic signed [52:0]  v7_reg [3];
    logic signed [31:0]  locy7_reg;
    logic [63:0]         sqd8_reg;
    logic [51:0]         mag8_reg [3];
    logic [2:0]          neg8_reg;
    logic signed [31:0]  locy8_reg;
    logic [63:0]         sqd9_reg;
    logic [51:0]         mag9_reg [3];
    logic [4:0]          k9_reg;
    logic [2:0]          neg9_reg;
    logic signed [31:0]  locy9_reg;
    logic [63:0]         sqd10_reg;
    logic [2:0][29:0]    sh10_reg;
    logic [2:0]          neg10_reg;
    logic signed [31:0]  locy10_reg;
    logic [63:0]         sqd11_reg;
    logic [59:0]         sqn11_reg [3];
    logic [2:0][29:0]    sh11_reg;
    logic [2:0]          neg11_reg;
    logic signed [31:0]  locy11_reg;

    root_st_t sqd_reg [ROOT_STEPS+1];
    root_st_t sqn_reg [ROOT_STEPS+1];
    root_cy_t rcy_reg [ROOT_STEPS+1];

    logic [32:0]         lend45_reg;
    logic [32:0]         lenn45_reg;
    root_cy_t            rcy45_reg;
    logic signed [58:0]  dprod46_reg;
    logic [46:0]         dvd46_reg [3];
    logic [32:0]         lenn46_reg;
    logic [2:0]          neg46_reg;
    logic signed [31:0]  locy46_reg;

    div_st_t dv_reg [DIV_STEPS+1][3];
    div_cy_t dcy_reg [DIV_STEPS+1];

    logic signed [31:0] dist_out_reg;
    logic [17:0]        nrm_out_reg [3];
    logic               outside_out_reg;

    assign scale     = scale_pair_reg[23:0];
    assign inv_scale = scale_pair_reg[47:24];
    assign radius    = shape_radius_reg[30:0];
    assign plane     = shape_radius_reg[31];

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_row_reg[0]   <= ROT_ROW0_RST;
            rot_row_reg[1]   <= ROT_ROW1_RST;
            rot_row_reg[2]   <= ROT_ROW2_RST;
            offset_reg[0]    <= '0;
            offset_reg[1]    <= '0;
            offset_reg[2]    <= '0;
            scale_pair_reg   <= SCALE_PAIR_RST;
            shape_radius_reg <= SHAPE_RADIUS_RST;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_ROT_ROW0:     rot_row_reg[0]   <= cfg_data;
                REG_ROT_ROW1:     rot_row_reg[1]   <= cfg_data;
                REG_ROT_ROW2:     rot_row_reg[2]   <= cfg_data;
                REG_OFFSET_X:     offset_reg[0]    <= cfg_data[31:0];
                REG_OFFSET_Y:     offset_reg[1]    <= cfg_data[31:0];
                REG_OFFSET_Z:     offset_reg[2]    <= cfg_data[31:0];
                REG_SCALE_PAIR:   scale_pair_reg   <= cfg_data[47:0];
                REG_SHAPE_RADIUS: shape_radius_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless the output item is held
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // stages 1 to 4: point into object frame
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg[0] <= $signed(s_tdata[31:0])  * $signed({1'b0, inv_scale});
            p1_reg[1] <= $signed(s_tdata[63:32]) * $signed({1'b0, inv_scale});
            p1_reg[2] <= $signed(s_tdata[95:64]) * $signed({1'b0, inv_scale});
            for (int j = 0; j < 3; j++) begin
                q2_reg[j] <= 41'((p1_reg[j] + 57'sd32768) >>> SCALE_FRAC);
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    m3_reg[i][j] <= rot_el(rot_row_reg[j], i) * q2_reg[j];
                end
                acc4_reg[i] <= 63'(m3_reg[i][0]) + 63'(m3_reg[i][1]) + 63'(m3_reg[i][2]);
            end
        end
    end

    // stage 5: round, remove offset, saturate
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [62:0] t;
                logic signed [45:0] d;
                t = (acc4_reg[i] + 63'sd131072) >>> ROT_FRAC;
                d = 46'($signed(t[44:0])) - 46'(offset_reg[i]);
                if (d > 46'sd2147483647) begin
                    loc5_reg[i] <= 32'sh7fffffff;
                end else if (d < -46'sd2147483648) begin
                    loc5_reg[i] <= 32'sh80000000;
                end else begin
                    loc5_reg[i] <= d[31:0];
                end
            end
        end
    end

    // stages 6 and 7: squares of local and rotated normal vector
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [63:0] sq;
                sq = loc5_reg[i] * loc5_reg[i];
                sqp6_reg[i] <= sq[62:0];
                for (int j = 0; j < 3; j++) begin
                    vp6_reg[i][j] <= rot_el(rot_row_reg[i], j) * loc5_reg[j];
                end
            end
            locy6_reg <= loc5_reg[1];
            sqd7_reg  <= 64'(sqp6_reg[0]) + 64'(sqp6_reg[1]) + 64'(sqp6_reg[2]);
            for (int i = 0; i < 3; i++) begin
                if (plane) begin
                    v7_reg[i] <= 53'(rot_el(rot_row_reg[i], 1));
                end else begin
                    v7_reg[i] <= 53'(vp6_reg[i][0]) + 53'(vp6_reg[i][1])
                                 + 53'(vp6_reg[i][2]);
                end
            end
            locy7_reg <= locy6_reg;
        end
    end

    // stages 8 to 11: magnitudes, shift count, truncation, squares
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [52:0] a;
                a = v7_reg[i][52] ? -v7_reg[i] : v7_reg[i];
                mag8_reg[i] <= a[51:0];
                neg8_reg[i] <= v7_reg[i][52];
            end
            sqd8_reg  <= sqd7_reg;
            locy8_reg <= locy7_reg;

            begin
                logic [51:0] orv;
                logic [4:0]  k;
                orv = mag8_reg[0] | mag8_reg[1] | mag8_reg[2];
                k = '0;
                for (int b = 30; b < 52; b++) begin
                    if (orv[b]) begin
                        k = 5'(b - 29);
                    end
                end
                k9_reg <= k;
            end
            mag9_reg  <= mag8_reg;
            neg9_reg  <= neg8_reg;
            sqd9_reg  <= sqd8_reg;
            locy9_reg <= locy8_reg;

            for (int i = 0; i < 3; i++) begin
                logic [51:0] s;
                s = mag9_reg[i] >> k9_reg;
                sh10_reg[i] <= s[29:0];
            end
            neg10_reg  <= neg9_reg;
            sqd10_reg  <= sqd9_reg;
            locy10_reg <= locy9_reg;

            for (int i = 0; i < 3; i++) begin
                sqn11_reg[i] <= sh10_reg[i] * sh10_reg[i];
            end
            sh11_reg   <= sh10_reg;
            neg11_reg  <= neg10_reg;
            sqd11_reg  <= sqd10_reg;
            locy11_reg <= locy10_reg;
        end
    end

    // stage 12: load both square roots
    always_ff @(posedge aclk) begin
        if (adv) begin
            sqd_reg[0].n <= sqd11_reg;
            sqd_reg[0].r <= '0;
            sqn_reg[0].n <= 64'(sqn11_reg[0]) + 64'(sqn11_reg[1]) + 64'(sqn11_reg[2]);
            sqn_reg[0].r <= '0;
            rcy_reg[0].loc_y <= locy11_reg;
            rcy_reg[0].neg   <= neg11_reg;
            rcy_reg[0].sh    <= sh11_reg;
        end
    end

    // square root, one bit pair per stage
    for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_root
        localparam logic [63:0] BIT_V = 64'd1 << (62 - 2 * s);
        always_ff @(posedge aclk) begin
            if (adv) begin
                sqd_reg[s+1] <= root_step(sqd_reg[s], BIT_V);
                sqn_reg[s+1] <= root_step(sqn_reg[s], BIT_V);
                rcy_reg[s+1] <= rcy_reg[s];
            end
        end
    end

    // round roots, then distance product and dividends
    always_ff @(posedge aclk) begin
        if (adv) begin
            lend45_reg <= sqd_reg[ROOT_STEPS].r[32:0]
                          + 33'(sqd_reg[ROOT_STEPS].n > sqd_reg[ROOT_STEPS].r);
            lenn45_reg <= sqn_reg[ROOT_STEPS].r[32:0]
                          + 33'(sqn_reg[ROOT_STEPS].n > sqn_reg[ROOT_STEPS].r);
            rcy45_reg  <= rcy_reg[ROOT_STEPS];

            begin
                logic signed [33:0] diff;
                diff = $signed({1'b0, lend45_reg}) - $signed({3'b0, radius});
                dprod46_reg <= diff * $signed({1'b0, scale});
            end
            for (int i = 0; i < 3; i++) begin
                dvd46_reg[i] <= {1'b0, rcy45_reg.sh[i], 16'b0} + 47'(lenn45_reg >> 1);
            end
            lenn46_reg <= lenn45_reg;
            neg46_reg  <= rcy45_reg.neg;
            locy46_reg <= rcy45_reg.loc_y;
        end
    end

    // distance round and saturate, divider setup
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic signed [58:0] t;
            logic signed [31:0] dsat;
            logic signed [31:0] dsel;
            t = (dprod46_reg + 59'sd32768) >>> SCALE_FRAC;
            if (t > 59'sd2147483647) begin
                dsat = 32'sh7fffffff;
            end else if (t < -59'sd2147483648) begin
                dsat = 32'sh80000000;
            end else begin
                dsat = t[31:0];
            end
            dsel = plane ? locy46_reg : dsat;
            dcy_reg[0].distance <= dsel;
            dcy_reg[0].outside  <= (dsel > 32'sd0);
            dcy_reg[0].len      <= lenn46_reg;
            dcy_reg[0].neg      <= neg46_reg;
            for (int i = 0; i < 3; i++) begin
                dv_reg[0][i].rem <= 34'(dvd46_reg[i][46:17]);
                dv_reg[0][i].dlo <= dvd46_reg[i][16:0];
                dv_reg[0][i].q   <= '0;
            end
        end
    end

    // normal divide, one quotient bit per stage
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int i = 0; i < 3; i++) begin
                    dv_reg[s+1][i] <= div_step(dv_reg[s][i], dcy_reg[s].len);
                end
                dcy_reg[s+1] <= dcy_reg[s];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            dist_out_reg    <= dcy_reg[DIV_STEPS].distance;
            outside_out_reg <= dcy_reg[DIV_STEPS].outside;
            for (int i = 0; i < 3; i++) begin
                logic [17:0] qv;
                qv = {1'b0, dv_reg[DIV_STEPS][i].q};
                if (dcy_reg[DIV_STEPS].len == '0) begin
                    nrm_out_reg[i] <= '0;
                end else if (dcy_reg[DIV_STEPS].neg[i]) begin
                    nrm_out_reg[i] <= -qv;
                end else begin
                    nrm_out_reg[i] <= qv;
                end
            end
        end
    end

    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_tdata  = {1'b0, outside_out_reg, nrm_out_reg[2], nrm_out_reg[1],
                       nrm_out_reg[0], dist_out_reg};

`ifndef NO_ASSERTIONS
    // outside flag agrees with the distance it came with
    a_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (outside_out_reg == (dist_out_reg > 32'sd0)))
        else $error("outside flag disagrees with distance");

    // quotient of a nonzero length never exceeds one
    a_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[PIPE_DEPTH-2] && dcy_reg[DIV_STEPS].len != '0) |->
        (dv_reg[DIV_STEPS][0].q <= 17'd65536 && dv_reg[DIV_STEPS][1].q <= 17'd65536
         && dv_reg[DIV_STEPS][2].q <= 17'd65536))
        else $error("normal component above unit length");

    // normal components stay in the unit range
    a_nrm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(nrm_out_reg[0]) <= 18'sd65536
                      && $signed(nrm_out_reg[0]) >= -18'sd65536
                      && $signed(nrm_out_reg[1]) <= 18'sd65536
                      && $signed(nrm_out_reg[1]) >= -18'sd65536
                      && $signed(nrm_out_reg[2]) <= 18'sd65536
                      && $signed(nrm_out_reg[2]) >= -18'sd65536))
        else $error("normal out of range");

    // nothing leaves right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("item out after reset");
`endif

endmodule
